@@ rtl/core/iros_pkg.sv @@
// ----------------------------------------------------------------------------
// iros_pkg
// Shared types and constants for the IR range obstacle steering block.
// ----------------------------------------------------------------------------
package iros_pkg;

  // ADC sample width and sensor count
  localparam int SAMPLE_BITS = 12;
  localparam int NUM_SENSORS = 5;

  // sensor lanes, outer left first
  localparam int S_OUTER_LEFT  = 0;
  localparam int S_LEFT        = 1;
  localparam int S_CENTRE      = 2;
  localparam int S_RIGHT       = 3;
  localparam int S_OUTER_RIGHT = 4;

  // distance divider: q = floor((K + 33 code) / (66 code))
  localparam int Q_BITS        = 15;
  localparam int DIV_BITS_STG  = 3;
  localparam int DIV_STAGES    = Q_BITS / DIV_BITS_STG;
  localparam int LANE_STAGES   = DIV_STAGES + 2;
  localparam int N_BITS        = SAMPLE_BITS + 18;
  localparam int D_BITS        = SAMPLE_BITS + 7;
  localparam int CMP_BITS      = D_BITS + Q_BITS;
  localparam int CLAMP_BITS    = SAMPLE_BITS + 8;
  localparam logic [N_BITS-1:0] DIV_NUM_BASE = N_BITS'(174080) << SAMPLE_BITS;

  // distance in unsigned Q8.8 cm
  localparam int DIST_BITS = 16;
  typedef logic [DIST_BITS-1:0] dist_t;
  localparam dist_t DIST_CLAMPED = 16'd25502;
  localparam dist_t DIST_OFFSET  = 16'd1280;
  localparam dist_t NEAR_LIMIT   = 16'd5120;
  localparam dist_t SIDE_LIMIT   = 16'd11520;
  localparam dist_t OUTER_KNEE   = 16'd2560;
  localparam dist_t CENTRE_LIMIT = 16'd10240;

  // offset numerators (scaled by 10000, plus half for rounding)
  localparam int M_BITS        = 29;
  localparam int OUTER_NEAR_A  = 24940168;
  localparam int OUTER_NEAR_B  = 4481;
  localparam int OUTER_FAR_A   = 12805000;
  localparam int OUTER_FAR_B   = 550;
  localparam int SIDE_A        = 12805000;
  localparam int SIDE_B        = 750;
  localparam int CENTRE_A      = 308805000;  // carries +200000000 bias
  localparam int CENTRE_B      = 12500;
  localparam int CENTRE_BIAS_Q = 20000;      // bias after the divide

  // divide by 10000 as multiply by reciprocal
  localparam int OFF_BITS    = 15;
  localparam int RECIP_SHIFT = 42;
  localparam logic [M_BITS-1:0] RECIP = 29'd439804652;

  // speed sum in signed Q12.8, turn bias in signed Q8.8
  localparam int SUM_BITS  = 20;
  localparam int TURN_BIAS = 2560;

  // total pipeline depth, last stage is the output register
  localparam int PIPE_STAGES = LANE_STAGES + 4;
  typedef logic [PIPE_STAGES-1:0] pipe_en_t;

  // configuration register map
  typedef enum logic [1:0] {
    CFG_AVOIDANCE_OFF  = 2'd0,
    CFG_MOTORS_STOPPED = 2'd1,
    CFG_BASE_SPEED     = 2'd2,
    CFG_FAST_SPEED     = 2'd3
  } cfg_reg_t;

endpackage

@@ rtl/core/iros_dist.sv @@
// ----------------------------------------------------------------------------
// iros_dist
// One sensor lane: ADC code to rounded Q8.8 distance through a pipelined
// restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module iros_dist
  import iros_pkg::*;
(
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic [SAMPLE_BITS-1:0] sample,
  output dist_t                  distance
);

  logic [N_BITS-1:0] rem_r   [DIV_STAGES+1];
  logic [Q_BITS-1:0] quo_r   [DIV_STAGES+1];
  logic [D_BITS-1:0] den_r   [DIV_STAGES+1];
  logic              clamp_r [DIV_STAGES+1];
  dist_t             dist_r;

  // build numerator, denominator and low-voltage clamp flag
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]   <= DIV_NUM_BASE + N_BITS'(sample) * N_BITS'(33);
      quo_r[0]   <= '0;
      den_r[0]   <= D_BITS'(sample) * D_BITS'(66);
      clamp_r[0] <= (CLAMP_BITS'(sample) * CLAMP_BITS'(132)) <
                    (CLAMP_BITS'(13) << SAMPLE_BITS);
    end
  end

  // divider stages
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [N_BITS-1:0] rem_nxt;
    logic [Q_BITS-1:0] quo_nxt;

    always_comb begin
      logic [CMP_BITS-1:0] sub;
      rem_nxt = rem_r[j-1];
      quo_nxt = quo_r[j-1];
      for (int b = 0; b < DIV_BITS_STG; b++) begin
        sub = CMP_BITS'(den_r[j-1]) << (Q_BITS - 1 - (DIV_BITS_STG * (j - 1) + b));
        if (CMP_BITS'(rem_nxt) >= sub) begin
          rem_nxt = rem_nxt - N_BITS'(sub);
          quo_nxt[Q_BITS - 1 - (DIV_BITS_STG * (j - 1) + b)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j]   <= rem_nxt;
        quo_r[j]   <= quo_nxt;
        den_r[j]   <= den_r[j-1];
        clamp_r[j] <= clamp_r[j-1];
      end
    end
  end

  // remove the offset or take the clamped distance
  always_ff @(posedge clk) begin
    if (en[LANE_STAGES-1]) begin
      dist_r <= clamp_r[DIV_STAGES] ? DIST_CLAMPED
                                    : DIST_BITS'(quo_r[DIV_STAGES]) - DIST_OFFSET;
    end
  end

  assign distance = dist_r;

endmodule

@@ rtl/core/ir_range_obstacle_steering.sv @@
// ----------------------------------------------------------------------------
// ir_range_obstacle_steering
// Reflex steering from five IR rangefinders: distances, near mask and
// saturated wheel speed commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: five ADC codes.
//   Result channel (out_valid / out_stall) returns one item per input:
//   left and right speed (signed Q8.8), speed_valid, cruising, near_mask.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_wdata) writes the
//   four registers; cfg_ready is always high. Write only while idle.
//   One item is taken per cycle while in_stall is low. The eleven
//   register stages are the input register, the five-stage distance
//   divider (three quotient bits per stage), the distance register, the
//   offset numerator and reciprocal multiply stages, the speed sum and
//   the output register.
//   When the receiver stalls, each stage holds while it is full and its
//   successor holds; empty stages still fill, and in_stall rises once
//   stage zero is full and blocked.
//   Reset empties the pipeline and loads avoidance_off=1, motors_stopped=0,
//   base_speed=5120, fast_speed=7680.
// ----------------------------------------------------------------------------
module ir_range_obstacle_steering
  import iros_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_outer_left,
  input  logic [SAMPLE_BITS-1:0] in_sample_left,
  input  logic [SAMPLE_BITS-1:0] in_sample_centre,
  input  logic [SAMPLE_BITS-1:0] in_sample_right,
  input  logic [SAMPLE_BITS-1:0] in_sample_outer_right,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_left_speed,
  output logic signed [15:0]     out_right_speed,
  output logic                   out_speed_valid,
  output logic                   out_cruising,
  output logic [NUM_SENSORS-1:0] out_near_mask,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  localparam int ST_CLASS = LANE_STAGES;
  localparam int ST_SCALE = LANE_STAGES + 1;
  localparam int ST_SUM   = LANE_STAGES + 2;
  localparam int ST_OUT   = LANE_STAGES + 3;

  // configuration registers
  logic               avoidance_off_r;
  logic               motors_stopped_r;
  logic signed [15:0] base_speed_r;
  logic signed [15:0] fast_speed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoidance_off_r  <= 1'b1;
      motors_stopped_r <= 1'b0;
      base_speed_r     <= 16'sd5120;
      fast_speed_r     <= 16'sd7680;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_AVOIDANCE_OFF:  avoidance_off_r  <= cfg_wdata[0];
        CFG_MOTORS_STOPPED: motors_stopped_r <= cfg_wdata[0];
        CFG_BASE_SPEED:     base_speed_r     <= cfg_wdata;
        CFG_FAST_SPEED:     fast_speed_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline valid bits and per-stage advance
  logic [PIPE_STAGES-1:0] vld_r;
  pipe_en_t               en;

  always_comb begin
    en[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // distance lanes
  logic [SAMPLE_BITS-1:0] sample    [NUM_SENSORS];
  dist_t                  lane_dist [NUM_SENSORS];

  assign sample[S_OUTER_LEFT]  = in_sample_outer_left;
  assign sample[S_LEFT]        = in_sample_left;
  assign sample[S_CENTRE]      = in_sample_centre;
  assign sample[S_RIGHT]       = in_sample_right;
  assign sample[S_OUTER_RIGHT] = in_sample_outer_right;

  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    iros_dist u_dist (
      .clk      (clk),
      .en       (en[LANE_STAGES-1:0]),
      .sample   (sample[i]),
      .distance (lane_dist[i])
    );
  end

  // classify: range flags, near mask, turn side, offset numerators
  logic [M_BITS-1:0]      num_r    [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] act_r;
  logic [NUM_SENSORS-1:0] near_c_r;
  logic                   cruise_c_r;
  logic                   turn_c_r;
  logic [M_BITS-1:0]      num_nxt  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] act_nxt;
  logic [NUM_SENSORS-1:0] near_nxt;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      near_nxt[i] = lane_dist[i] <= NEAR_LIMIT;
      act_nxt[i]  = (i == S_CENTRE) ? (lane_dist[i] <= CENTRE_LIMIT)
                                    : (lane_dist[i] <= SIDE_LIMIT);
      if (i == S_CENTRE) begin
        num_nxt[i] = M_BITS'(34'(CENTRE_A) - 34'(lane_dist[i]) * 34'(CENTRE_B));
      end else if (i == S_LEFT || i == S_RIGHT) begin
        num_nxt[i] = M_BITS'(34'(SIDE_A) - 34'(lane_dist[i]) * 34'(SIDE_B));
      end else if (lane_dist[i] <= OUTER_KNEE) begin
        num_nxt[i] = M_BITS'(34'(OUTER_NEAR_A) - 34'(lane_dist[i]) * 34'(OUTER_NEAR_B));
      end else begin
        num_nxt[i] = M_BITS'(34'(OUTER_FAR_A) - 34'(lane_dist[i]) * 34'(OUTER_FAR_B));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CLASS]) begin
      num_r      <= num_nxt;
      act_r      <= act_nxt;
      near_c_r   <= near_nxt;
      cruise_c_r <= !(|act_nxt);
      turn_c_r   <= (17'(lane_dist[S_OUTER_LEFT]) + 17'(lane_dist[S_LEFT])) >
                    (17'(lane_dist[S_OUTER_RIGHT]) + 17'(lane_dist[S_RIGHT]));
    end
  end

  // scale: divide numerators by 10000 through the reciprocal
  logic [OFF_BITS-1:0]    off_r    [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] act_s_r;
  logic [NUM_SENSORS-1:0] near_s_r;
  logic                   cruise_s_r;
  logic                   turn_s_r;

  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_scale
    logic [2*M_BITS-1:0] product;
    assign product = (2*M_BITS)'(num_r[i]) * (2*M_BITS)'(RECIP);
    always_ff @(posedge clk) begin
      if (en[ST_SCALE]) off_r[i] <= product[RECIP_SHIFT +: OFF_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SCALE]) begin
      act_s_r    <= act_r;
      near_s_r   <= near_c_r;
      cruise_s_r <= cruise_c_r;
      turn_s_r   <= turn_c_r;
    end
  end

  // sum: add signed offsets to the base speed
  logic signed [SUM_BITS-1:0] left_sum_r;
  logic signed [SUM_BITS-1:0] right_sum_r;
  logic [NUM_SENSORS-1:0]     near_m_r;
  logic                       cruise_m_r;
  logic signed [SUM_BITS-1:0] t_nxt [NUM_SENSORS];
  logic signed [SUM_BITS-1:0] cen_c;
  logic signed [SUM_BITS-1:0] bias;
  logic signed [SUM_BITS-1:0] left_nxt;
  logic signed [SUM_BITS-1:0] right_nxt;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      t_nxt[i] = act_s_r[i] ? signed'(SUM_BITS'(off_r[i])) : '0;
    end
    cen_c = signed'(SUM_BITS'(off_r[S_CENTRE])) - SUM_BITS'(CENTRE_BIAS_Q);
    bias  = turn_s_r ? SUM_BITS'(TURN_BIAS) : -SUM_BITS'(TURN_BIAS);
    left_nxt  = SUM_BITS'(base_speed_r) + t_nxt[S_OUTER_LEFT] + t_nxt[S_LEFT]
              - t_nxt[S_RIGHT] - t_nxt[S_OUTER_RIGHT];
    right_nxt = SUM_BITS'(base_speed_r) - t_nxt[S_OUTER_LEFT] - t_nxt[S_LEFT]
              + t_nxt[S_RIGHT] + t_nxt[S_OUTER_RIGHT];
    if (act_s_r[S_CENTRE]) begin
      left_nxt  = left_nxt - (cen_c + bias);
      right_nxt = right_nxt - (cen_c - bias);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      left_sum_r  <= left_nxt;
      right_sum_r <= right_nxt;
      near_m_r    <= near_s_r;
      cruise_m_r  <= cruise_s_r;
    end
  end

  // output: mode select and saturation
  function automatic logic signed [15:0] sat16(input logic signed [SUM_BITS-1:0] v);
    if (v > SUM_BITS'(32767)) return 16'sh7fff;
    if (v < -SUM_BITS'(32768)) return 16'sh8000;
    return 16'(v);
  endfunction

  logic signed [15:0]     left_r;
  logic signed [15:0]     right_r;
  logic                   speed_valid_r;
  logic                   cruising_r;
  logic [NUM_SENSORS-1:0] near_mask_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      cruising_r  <= cruise_m_r;
      near_mask_r <= near_m_r;
      if (motors_stopped_r) begin
        left_r        <= '0;
        right_r       <= '0;
        speed_valid_r <= 1'b1;
      end else if (avoidance_off_r) begin
        left_r        <= '0;
        right_r       <= '0;
        speed_valid_r <= 1'b0;
      end else if (cruise_m_r) begin
        left_r        <= fast_speed_r;
        right_r       <= fast_speed_r;
        speed_valid_r <= 1'b1;
      end else begin
        left_r        <= sat16(left_sum_r);
        right_r       <= sat16(right_sum_r);
        speed_valid_r <= 1'b1;
      end
    end
  end

  assign out_left_speed  = left_r;
  assign out_right_speed = right_r;
  assign out_speed_valid = speed_valid_r;
  assign out_cruising    = cruising_r;
  assign out_near_mask   = near_mask_r;

endmodule
